// ----- rtl/mcg_pkg.sv -----
// ----------------------------------------------------------------------------
// mcg_pkg
// Types, constants and widths shared by the MIDI beat clock generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcg_pkg;

   localparam int ACC_FRACTION_BITS = 16;
   localparam int POSITION_BITS     = 48;

   localparam int RATE_W      = 18;
   localparam int TEMPO_W     = 20;
   localparam int POS_FIELD_W = 48;
   localparam int ACC_W       = 56;
   localparam int BEATS_W     = 14;

   localparam int POS_W = (POSITION_BITS < POS_FIELD_W) ? POSITION_BITS : POS_FIELD_W;

   // rate * 2500 for the clock interval, rate * 15000 for song position
   localparam int INTERVAL_SCALE   = 2500;
   localparam int INTERVAL_SCALE_W = 12;
   localparam int SPP_SCALE        = 15000;
   localparam int SPP_SCALE_W      = 14;

   localparam int NUM_W  = RATE_W + INTERVAL_SCALE_W;
   localparam int INT_W  = NUM_W + ACC_FRACTION_BITS + 1;
   localparam int D_W    = RATE_W + SPP_SCALE_W;
   localparam int DVS_W  = D_W + 1;
   localparam int REM_W  = DVS_W + 1;
   localparam int PROD_W = POS_W + TEMPO_W;
   localparam int X_W    = PROD_W + 1;
   localparam int DIV_W  = (X_W > INT_W) ? X_W : INT_W;
   localparam int Q_W    = INT_W;
   localparam int STEP_W = $clog2(DIV_W + 1);
   localparam int TCNT_W = $clog2(TEMPO_W + 1);
   localparam int SUM_W  = ACC_W + 2;

   localparam logic [RATE_W-1:0]  RATE_RESET    = RATE_W'(48000);
   localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = TEMPO_W'(120000);
   localparam logic [BEATS_W-1:0] BEATS_MAX     = '1;
   localparam logic [ACC_W-1:0]   ACC_MIN       = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [7:0] MIDI_CLOCK    = 8'hF8;
   localparam logic [7:0] MIDI_START    = 8'hFA;
   localparam logic [7:0] MIDI_CONTINUE = 8'hFB;
   localparam logic [7:0] MIDI_STOP     = 8'hFC;
   localparam logic [7:0] MIDI_SONG_POS = 8'hF2;

   typedef struct packed {
      logic                   is_playing;
      logic [TEMPO_W-1:0]     tempo_milli_bpm;
      logic [POS_FIELD_W-1:0] song_position_samples;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] status_byte;
      logic [6:0] data_low;
      logic [6:0] data_high;
      logic       last_of_run;
   } rsp_payload_type;

   function automatic rsp_payload_type make_msg(logic [7:0] status,
                                                logic [BEATS_W-1:0] beats,
                                                logic last);
      rsp_payload_type m;
      m.status_byte = status;
      m.data_low    = beats[6:0];
      m.data_high   = beats[13:7];
      m.last_of_run = last;
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/midi_clock_generator.sv -----
// ----------------------------------------------------------------------------
// midi_clock_generator
// MIDI beat clock at 24 pulses per quarter note, driven by audio sample ticks.
// ----------------------------------------------------------------------------
// A stop edge queues its STOP message straight from idle. A playing tick goes through
// prep, a 47-step bit-serial interval division and finish; a start with nonzero
// position adds a 20-step multiply, a sum and a 69-step division. The divider gives one
// bit per cycle; messages leave one per cycle while the output does not stall.
// Reset is synchronous: rate 48000, accumulator zero, stopped; no clearing pass.
`default_nettype none

module midi_clock_generator (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire mcg_pkg::req_payload_type req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output mcg_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [17:0]              csr_data
);
   import mcg_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_PREP   = 7'b0000010,
      S_DIV    = 7'b0000100,
      S_MUL    = 7'b0001000,
      S_SUM    = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [RATE_W-1:0]     rate_ff;
   logic [NUM_W-1:0]      num_ff;
   logic [D_W-1:0]        d_ff;
   logic                  was_ff, was_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [TEMPO_W-1:0]    tempo_ff, tempo_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [DVS_W-1:0]      dvs_ff, dvs_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [Q_W-1:0]        quo_ff, quo_in;
   logic                  sticky_ff, sticky_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic                  spp_ff, spp_in;
   logic [Q_W-1:0]        interval_ff, interval_in;
   logic [BEATS_W-1:0]    beats_ff, beats_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [TEMPO_W-1:0]    tsh_ff, tsh_in;
   logic [TCNT_W-1:0]     mcnt_ff, mcnt_in;
   rsp_payload_type       q0_ff, q0_in, q1_ff, q1_in, q2_ff, q2_in;
   logic [1:0]            qn_ff, qn_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic                  slot_free;
   logic [REM_W-1:0]      rem_shift;
   logic                  rem_ge;
   logic [Q_W-1:0]        quo_step;
   logic                  sticky_step;
   logic                  spp_sat;
   logic                  edge_start;
   logic                  pos_zero;
   logic [ACC_W-1:0]      acc_base;
   logic                  fire;
   logic [SUM_W-1:0]      acc_sum;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;
   assign slot_free   = !rsp_valid_ff || !rsp_stall;

   // divider step
   assign rem_shift   = {rem_ff[REM_W-2:0], div_ff[DIV_W-1]};
   assign rem_ge      = rem_shift >= REM_W'(dvs_ff);
   assign quo_step    = {quo_ff[Q_W-2:0], rem_ge};
   assign sticky_step = sticky_ff | quo_ff[Q_W-1];
   assign spp_sat     = sticky_step || (quo_step[Q_W-1:BEATS_W] != '0);

   // accumulator update
   assign edge_start = !was_ff;
   assign pos_zero   = (pos_ff == '0);
   assign acc_base   = edge_start ? '0 : acc_ff;
   assign fire       = acc_base[ACC_W-1] || (acc_base == '0);
   assign acc_sum    = {{2{acc_base[ACC_W-1]}}, acc_base}
                     + (fire ? SUM_W'(interval_ff) : '0)
                     - (SUM_W'(1) << ACC_FRACTION_BITS);

   always_comb begin
      state_in     = state_ff;
      was_in       = was_ff;
      acc_in       = acc_ff;
      tempo_in     = tempo_ff;
      pos_in       = pos_ff;
      div_in       = div_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sticky_in    = sticky_ff;
      cnt_in       = cnt_ff;
      spp_in       = spp_ff;
      interval_in  = interval_ff;
      beats_in     = beats_ff;
      prod_in      = prod_ff;
      tsh_in       = tsh_ff;
      mcnt_in      = mcnt_ff;
      q0_in        = q0_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      qn_in        = qn_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               tempo_in = (req_payload.tempo_milli_bpm == '0) ? DEFAULT_TEMPO
                                                              : req_payload.tempo_milli_bpm;
               pos_in   = req_payload.song_position_samples[POS_W-1:0];
               if (req_payload.is_playing) begin
                  state_in = S_PREP;
               end else begin
                  acc_in = '0;
                  was_in = 1'b0;
                  if (was_ff) begin
                     q0_in    = make_msg(MIDI_STOP, '0, 1'b1);
                     qn_in    = 2'd1;
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_PREP: begin
            div_in    = DIV_W'((INT_W'(num_ff) << ACC_FRACTION_BITS)
                               + INT_W'(tempo_ff >> 1)) << (DIV_W - INT_W);
            dvs_in    = DVS_W'(tempo_ff);
            rem_in    = '0;
            quo_in    = '0;
            sticky_in = 1'b0;
            cnt_in    = STEP_W'(INT_W);
            spp_in    = 1'b0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            div_in    = div_ff << 1;
            rem_in    = rem_ge ? rem_shift - REM_W'(dvs_ff) : rem_shift;
            quo_in    = quo_step;
            sticky_in = sticky_step;
            cnt_in    = cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               if (spp_ff) begin
                  beats_in = spp_sat ? BEATS_MAX : quo_step[BEATS_W-1:0];
                  state_in = S_FINISH;
               end else begin
                  interval_in = quo_step;
                  if (edge_start && !pos_zero) begin
                     prod_in  = '0;
                     tsh_in   = tempo_ff;
                     mcnt_in  = TCNT_W'(TEMPO_W);
                     state_in = S_MUL;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_MUL: begin
            prod_in = (prod_ff << 1) + (tsh_ff[TEMPO_W-1] ? PROD_W'(pos_ff) : '0);
            tsh_in  = tsh_ff << 1;
            mcnt_in = mcnt_ff - TCNT_W'(1);
            if (mcnt_ff == TCNT_W'(1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            // 2 * pos * tempo + d, divided by 2 * d: rounded half up
            div_in    = DIV_W'((X_W'(prod_ff) << 1) + X_W'(d_ff)) << (DIV_W - X_W);
            dvs_in    = {d_ff, 1'b0};
            rem_in    = '0;
            quo_in    = '0;
            sticky_in = 1'b0;
            cnt_in    = STEP_W'(X_W);
            spp_in    = 1'b1;
            state_in  = S_DIV;
         end
         S_FINISH: begin
            was_in = 1'b1;
            acc_in = ($signed(acc_sum) < $signed({2'b11, ACC_MIN})) ? ACC_MIN
                                                                     : acc_sum[ACC_W-1:0];
            if (edge_start && pos_zero) begin
               q0_in = make_msg(MIDI_START, '0, 1'b0);
               q1_in = make_msg(MIDI_CLOCK, '0, 1'b1);
               qn_in = 2'd2;
            end else if (edge_start) begin
               q0_in = make_msg(MIDI_SONG_POS, beats_ff, 1'b0);
               q1_in = make_msg(MIDI_CONTINUE, '0, 1'b0);
               q2_in = make_msg(MIDI_CLOCK, '0, 1'b1);
               qn_in = 2'd3;
            end else begin
               q0_in = make_msg(MIDI_CLOCK, '0, 1'b1);
               qn_in = fire ? 2'd1 : 2'd0;
            end
            state_in = (edge_start || fire) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = q0_ff;
               q0_in        = q1_ff;
               q1_in        = q2_ff;
               qn_in        = qn_ff - 2'd1;
               if (qn_ff == 2'd1) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= RATE_RESET;
         was_ff       <= 1'b0;
         acc_ff       <= '0;
         qn_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         was_ff       <= was_in;
         acc_ff       <= acc_in;
         qn_ff        <= qn_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            rate_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= NUM_W'(rate_ff) * NUM_W'(INTERVAL_SCALE);
      d_ff        <= D_W'(rate_ff) * D_W'(SPP_SCALE);
      tempo_ff    <= tempo_in;
      pos_ff      <= pos_in;
      div_ff      <= div_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sticky_ff   <= sticky_in;
      cnt_ff      <= cnt_in;
      spp_ff      <= spp_in;
      interval_ff <= interval_in;
      beats_ff    <= beats_in;
      prod_ff     <= prod_in;
      tsh_ff      <= tsh_in;
      mcnt_ff     <= mcnt_in;
      q0_ff       <= q0_in;
      q1_ff       <= q1_in;
      q2_ff       <= q2_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_stopped_acc_zero: assert property (@(posedge clock) disable iff (reset)
      !was_ff |-> acc_ff == '0)
      else $error("accumulator not held at zero while stopped");

   a_accept_queue_empty: assert property (@(posedge clock) disable iff (reset)
      req_take |-> qn_ff == 2'd0)
      else $error("tick accepted with messages still queued");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> qn_ff != 2'd0)
      else $error("emit state with empty queue");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff != '0)
      else $error("divider running with zero step count");

   a_stop_only_playing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_take && !req_payload.is_playing && was_ff)
      |=> state_ff == S_EMIT && q0_ff.status_byte == MIDI_STOP)
      else $error("stop transaction not queued");

endmodule

`default_nettype wire

// ----- dv/mcg_checker.sv -----
// ----------------------------------------------------------------------------
// mcg_checker
// Watches the tick, message and rate channels of the MIDI beat clock
// generator. Keeps its own copy of the transport state and the clock
// accumulator, works out the MIDI messages that every accepted tick must
// produce and compares each message that leaves the block, field by field,
// against the oldest one still owed.
// ----------------------------------------------------------------------------
module mcg_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  mcg_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  mcg_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [17:0]              csr_data,
   output int unsigned              mismatch_count,
   output int unsigned              msgs_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;
   import mcg_pkg::*;

   localparam longint ACC_FLOOR  = -(longint'(1) << (ACC_W - 1));
   localparam longint ONE_SAMPLE = longint'(1) << ACC_FRACTION_BITS;

   rsp_payload_type  owed_msgs[$];
   longint unsigned  rate_hz;
   longint           clock_acc;
   logic             transport_running;

   function automatic rsp_payload_type midi_msg(logic [7:0] status, logic [13:0] beats);
      rsp_payload_type m;
      m.status_byte = status;
      m.data_low    = beats[6:0];
      m.data_high   = beats[13:7];
      m.last_of_run = 1'b0;
      return m;
   endfunction

   // song position in sixteenth notes, rounded half up, saturated to 14 bits
   function automatic logic [13:0] sixteenths(longint unsigned pos, longint unsigned tempo,
                                              longint unsigned rate);
      longint unsigned d, q, r, b;
      d = 64'd15000 * rate;
      if (d == 0) return BEATS_MAX;
      q = pos / d;
      r = pos % d;
      if (q >= 64'h4000) return BEATS_MAX;
      b = q * tempo + (64'd2 * r * tempo + d) / (64'd2 * d);
      return (b > 64'h3FFF) ? BEATS_MAX : b[13:0];
   endfunction

   task automatic derive_midi_msgs(req_payload_type t);
      rsp_payload_type msgs[$];
      longint unsigned tempo, pos, interval;
      tempo = t.tempo_milli_bpm;
      if (tempo == 0) tempo = DEFAULT_TEMPO;
      pos = t.song_position_samples & ((64'd1 << POSITION_BITS) - 64'd1);
      if (t.is_playing) begin
         interval = (((rate_hz * 64'd2500) << ACC_FRACTION_BITS) + tempo / 2) / tempo;
         if (!transport_running) begin
            if (pos == 0) begin
               msgs = {msgs, midi_msg(MIDI_START, '0)};
            end else begin
               msgs = {msgs, midi_msg(MIDI_SONG_POS, sixteenths(pos, tempo, rate_hz))};
               msgs = {msgs, midi_msg(MIDI_CONTINUE, '0)};
            end
            clock_acc = 0;
         end
         if (clock_acc <= 0) begin
            msgs = {msgs, midi_msg(MIDI_CLOCK, '0)};
            clock_acc += longint'(interval);
         end
         clock_acc -= ONE_SAMPLE;
         if (clock_acc < ACC_FLOOR) clock_acc = ACC_FLOOR;
      end else begin
         if (transport_running) msgs = {msgs, midi_msg(MIDI_STOP, '0)};
         clock_acc = 0;
      end
      transport_running = t.is_playing;
      if (msgs.size() > 0) msgs[msgs.size() - 1].last_of_run = 1'b1;
      owed_msgs = {owed_msgs, msgs};
   endtask

   task automatic check_msg(rsp_payload_type got);
      rsp_payload_type exp;
      if (owed_msgs.size() == 0) begin
         $display("%0t: expected no message, actual status=%02h lo=%02h hi=%02h last=%0b",
                  $realtime, got.status_byte, got.data_low, got.data_high,
                  got.last_of_run);
         mismatch_count++;
         return;
      end
      exp = owed_msgs.pop_front();
      if (got !== exp) begin
         if (got.status_byte !== exp.status_byte)
            $display("%0t: status_byte expected %02h actual %02h",
                     $realtime, exp.status_byte, got.status_byte);
         if (got.data_low !== exp.data_low)
            $display("%0t: data_low expected %02h actual %02h",
                     $realtime, exp.data_low, got.data_low);
         if (got.data_high !== exp.data_high)
            $display("%0t: data_high expected %02h actual %02h",
                     $realtime, exp.data_high, got.data_high);
         if (got.last_of_run !== exp.last_of_run)
            $display("%0t: last_of_run expected %0b actual %0b",
                     $realtime, exp.last_of_run, got.last_of_run);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         owed_msgs.delete();
         rate_hz           = RATE_RESET;
         clock_acc         = 0;
         transport_running = 1'b0;
      end else begin
         if (csr_valid && csr_ready) rate_hz = csr_data;
         // a message can never belong to a tick accepted on the same edge
         if (rsp_valid && !rsp_stall) check_msg(rsp_payload);
         if (req_valid && !req_stall) derive_midi_msgs(req_payload);
      end
      msgs_in_flight <= owed_msgs.size();
   end

endmodule

// ----- dv/tb_midi_clock_generator.sv -----
// ----------------------------------------------------------------------------
// tb_midi_clock_generator
// Drives audio sample ticks into the MIDI beat clock generator: a directed
// set of transport edges and tempo/position extremes, then random play runs
// over several sample rates, including zero and the register maximum. Both
// channels idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_midi_clock_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import mcg_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 200;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [17:0]     csr_data;

   int unsigned mismatch_count;
   int unsigned msgs_in_flight;
   int unsigned ticks_sent;
   int unsigned quiet_cycles;
   bit          tail_quiet;
   bit          gappy;

   always #5ns clock = ~clock;

   midi_clock_generator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   mcg_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .msgs_in_flight (msgs_in_flight)
   );

   task automatic send_tick(bit play, logic [19:0] tempo, logic [47:0] pos);
      req_payload_type t;
      t.is_playing            = play;
      t.tempo_milli_bpm       = tempo;
      t.song_position_samples = pos;
      req_valid   <= 1'b1;
      req_payload <= t;
      do @(posedge clock); while (req_stall);
      ticks_sent++;
      if (!tail_quiet && gappy && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // register writes only once the block has gone quiet
   task automatic write_rate(logic [17:0] rate);
      req_valid <= 1'b0;
      @(posedge clock);
      while (msgs_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= rate;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [19:0] rand_tempo();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return 20'($urandom_range(0, 20'hFFFFF));
         default: return 20'($urandom_range(400000, 999999));
      endcase
   endfunction

   function automatic logic [47:0] rand_pos();
      logic [47:0] p;
      p = {16'($urandom), 32'($urandom)};
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return p;
         default: return p >> $urandom_range(16, 47);
      endcase
   endfunction

   // play runs with random content; some runs skip the stop or start noisy
   task automatic play_session(int unsigned n_ticks);
      int unsigned goal, len;
      logic [19:0] tempo;
      goal = ticks_sent + n_ticks;
      while (ticks_sent < goal) begin
         len   = $urandom_range(3, 30);
         gappy = ($urandom_range(0, 2) != 0);
         tempo = rand_tempo();
         if ($urandom_range(0, 5) == 0) send_tick(1'b0, rand_tempo(), rand_pos());
         repeat (len) begin
            if ($urandom_range(0, 7) == 0) tempo = rand_tempo();
            send_tick(1'b1, tempo, rand_pos());
         end
         if ($urandom_range(0, 4) != 0) send_tick(1'b0, rand_tempo(), rand_pos());
      end
      send_tick(1'b0, rand_tempo(), rand_pos());
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      rsp_stall   <= 1'b0;
      csr_valid   <= 1'b0;
      csr_data    <= '0;
      ticks_sent  = 0;
      tail_quiet  = 1'b0;
      gappy       = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset rate
      send_tick(1'b0, '0, '0);
      send_tick(1'b1, '0, '0);
      send_tick(1'b1, '0, '0);
      send_tick(1'b0, '0, '0);
      send_tick(1'b1, 20'd999999, 48'd1);
      send_tick(1'b0, 20'd999999, '1);
      send_tick(1'b1, 20'hFFFFF, '1);
      send_tick(1'b1, 20'hFFFFF, '1);
      send_tick(1'b0, 20'h00001, '0);
      send_tick(1'b1, 20'h00001, 48'd720000000);
      send_tick(1'b1, 20'h00001, '0);
      send_tick(1'b0, 20'hFFFFF, '1);
      send_tick(1'b1, 20'd120000, 48'd360000);
      send_tick(1'b0, 20'd120000, '0);
      send_tick(1'b1, 20'd120000, 48'd359999);
      send_tick(1'b0, '0, '0);
      send_tick(1'b1, 20'd999999, 48'h5555_5555_5555);
      send_tick(1'b0, 20'h55555, 48'hAAAA_AAAA_AAAA);
      send_tick(1'b0, 20'hAAAAA, 48'h5555_5555_5555);

      write_rate(18'd8000);
      play_session(40);
      write_rate(18'd0);
      play_session(40);
      write_rate(18'd100);
      play_session(35);
      write_rate(18'd192000);
      play_session(35);
      write_rate(18'h3FFFF);
      play_session(35);
      write_rate(18'($urandom_range(8000, 192000)));
      play_session(40);
      write_rate(18'($urandom_range(8000, 20000)));
      tail_quiet = 1'b1;
      play_session(40);

      req_valid <= 1'b0;
      @(posedge clock);
      while (msgs_in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && msgs_in_flight == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      @(negedge reset);
      forever begin
         if (tail_quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

endmodule

// ----- files.f -----
rtl/mcg_pkg.sv
rtl/midi_clock_generator.sv
dv/mcg_checker.sv
dv/tb_midi_clock_generator.sv
